FILE: src/ssett_pkg.sv
// Shared constants and types for the sorted set table.
package ssett_pkg;

  localparam int DATA_W      = 32;
  localparam int MODE_W      = 2;
  localparam int TOTAL_W     = 7;
  localparam int CAPACITY_DF = 64;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  typedef logic signed [DATA_W-1:0] elem_t;

endpackage

FILE: src/ssett_ram.sv
// Element store: one write port, one read port, registered read data.
module ssett_ram #(
  parameter int DEPTH = ssett_pkg::CAPACITY_DF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  ssett_pkg::elem_t    wdata,
  output ssett_pkg::elem_t    rdata
);
  import ssett_pkg::*;

  elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sorted_set_table_top.sv
// Sorted set table: top level with the scan/shift sequencer.
//
//  channel   dir   handshake            payload
//  --------  ----  -------------------  ------------------------------------
//  command   in    start & !busy        mode[1:0], value[31:0] signed
//  result    out   done (1-cycle pulse) was_present, element_total[6:0],
//                                       full_refused
//
// An item scans the held entries in order, stopping early when it can. The
// one-read/one-write element RAM sets the pace: each cycle reads one entry
// and, while shifting, writes the previous one.
// Reset (rst, synchronous) empties the set; RAM contents are left as is.
// The result pulses on done for one cycle; the receiver cannot stall it.
// busy is high while an item is in work; start is ignored then.
module sorted_set_table_top #(
  parameter int CAPACITY = ssett_pkg::CAPACITY_DF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ssett_pkg::MODE_W-1:0]  mode,
  input  ssett_pkg::elem_t              value,
  output logic                          done,
  output logic                          was_present,
  output logic [ssett_pkg::TOTAL_W-1:0] element_total,
  output logic                          full_refused
);
  import ssett_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > TOTAL_W) ? CW : TOTAL_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;

  // scan phases
  localparam logic [1:0] PH_SEARCH = 2'd0;  // still looking for position
  localparam logic [1:0] PH_INS    = 2'd1;  // rippling larger entries up
  localparam logic [1:0] PH_REM    = 2'd2;  // pulling larger entries down

  logic [1:0]        state, state_next;
  logic [1:0]        phase, phase_next;
  logic [MODE_W-1:0] mode_r, mode_r_next;
  elem_t             value_r, value_r_next;
  elem_t             carry, carry_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     count, count_next;
  logic              done_next;
  logic              present, present_next;
  logic              refused, refused_next;

  logic              re, we;
  logic [AW-1:0]     raddr, waddr;
  elem_t             wdata, rdata;

  logic [CW-1:0]     idx_inc;
  logic              hit, above, finish;
  logic              is_ins, is_rem;
  logic [XW-1:0]     total_ext;

  ssett_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .re    (re),
    .raddr (raddr),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign idx_inc = idx + CW'(1);
  assign hit     = (rdata == value_r);
  assign above   = (rdata > value_r);
  assign is_ins  = (mode_r == MODE_INSERT);
  assign is_rem  = (mode_r == MODE_REMOVE);

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    mode_r_next  = mode_r;
    value_r_next = value_r;
    carry_next   = carry;
    idx_next     = idx;
    count_next   = count;
    present_next = present;
    refused_next = refused;
    finish       = 1'b0;
    re           = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = idx[AW-1:0];
    wdata        = value_r;

    case (state)
      S_IDLE: begin
        if (start) begin
          mode_r_next  = mode;
          value_r_next = value;
          phase_next   = PH_SEARCH;
          idx_next     = '0;
          present_next = 1'b0;
          refused_next = 1'b0;
          if (count != '0) begin
            re         = 1'b1;
            state_next = S_SCAN;
          end else begin
            state_next = S_TAIL;
          end
        end
      end

      S_SCAN: begin
        // rdata holds entry idx
        case (phase)
          PH_SEARCH: begin
            if (hit) begin
              present_next = 1'b1;
              if (is_rem) begin
                phase_next = PH_REM;
              end else begin
                finish = 1'b1;
              end
            end else if (above) begin
              if (is_ins && count != CAP_C) begin
                we         = 1'b1;
                wdata      = value_r;
                carry_next = rdata;
                phase_next = PH_INS;
              end else begin
                refused_next = is_ins;
                finish       = 1'b1;
              end
            end
          end
          PH_INS: begin
            we         = 1'b1;
            wdata      = carry;
            carry_next = rdata;
          end
          PH_REM: begin
            we    = 1'b1;
            waddr = AW'(idx - CW'(1));
            wdata = rdata;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (!finish) begin
          idx_next = idx_inc;
          if (idx_inc < count) begin
            re    = 1'b1;
            raddr = idx_inc[AW-1:0];
          end else begin
            state_next = S_TAIL;
          end
        end
      end

      S_TAIL: begin
        // idx == count: past the last element
        finish = 1'b1;
        case (phase)
          PH_SEARCH: begin
            if (is_ins) begin
              if (count == CAP_C) begin
                refused_next = 1'b1;
              end else begin
                we         = 1'b1;
                wdata      = value_r;
                count_next = count + CW'(1);
              end
            end
          end
          PH_INS: begin
            we         = 1'b1;
            wdata      = carry;
            count_next = count + CW'(1);
          end
          PH_REM: begin
            count_next = count - CW'(1);
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      state_next = S_IDLE;
    end
    done_next = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_SEARCH;
      count   <= '0;
      done    <= 1'b0;
      present <= 1'b0;
      refused <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      count   <= count_next;
      done    <= done_next;
      present <= present_next;
      refused <= refused_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    mode_r  <= mode_r_next;
    value_r <= value_r_next;
    carry   <= carry_next;
    idx     <= idx_next;
  end

  assign busy          = (state != S_IDLE);
  assign was_present   = present;
  assign full_refused  = refused;
  assign total_ext     = XW'(count);
  assign element_total = total_ext[TOTAL_W-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C) else $error("element count above capacity");

  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    (done && full_refused) |-> (count == CAP_C && !was_present))
    else $error("refusal without a full store");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("accepted item not in work");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !done |=> (count == $past(count)) || $past(done_next))
    else $error("count changed without a result");

endmodule

FILE: sim/sorted_set_table_top_tb.sv
// Self-checking testbench for the sorted set table: directed and random insert/remove/query items.
`timescale 1ns / 1ps

module sorted_set_table_top_tb;
  import ssett_pkg::*;

  localparam int CAP = CAPACITY_DF;
  // Mode code three is unused by the block; it must behave like a query.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // The limit is several times the slowest full run, with every item at its
  // slowest and every idle gap at its longest.
  localparam int CYCLE_LIMIT = 500_000;
  localparam int TAIL_CYCLES = CAP + 8;

  localparam elem_t ELEM_MIN = 32'sh8000_0000;
  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;

  // One command item waiting to go out, with the idle cycles before it.
  typedef struct {
    logic [MODE_W-1:0] op;
    elem_t             val;
    int                gap;
  } cmd_item_t;

  // One expected result item.
  typedef struct packed {
    logic               was_present;
    logic [TOTAL_W-1:0] total;
    logic               refused;
  } set_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [MODE_W-1:0]  mode = MODE_QUERY;
  elem_t              value = '0;
  logic               busy;
  logic               done;
  logic               was_present;
  logic [TOTAL_W-1:0] element_total;
  logic               full_refused;

  sorted_set_table_top #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .done         (done),
    .was_present  (was_present),
    .element_total(element_total),
    .full_refused (full_refused)
  );

  // Command items not yet offered, and results predicted but not yet seen.
  cmd_item_t   cmd_queue[$];
  set_result_t expected_results[$];

  // Predictor state: ascending copy of the set and its element count.
  elem_t set_image[CAP];
  int    held_total = 0;

  // Every fresh random value generated so far; reused so removes and queries hit.
  elem_t seen_values[$];

  cmd_item_t issue_cmd;
  set_result_t want;
  int  accepted_count = 0;
  int  issued_total = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one item to the predicted set and queue the result it yields.
  task automatic apply_set_op(input logic [MODE_W-1:0] op, input elem_t v);
    int          pos;
    bit          hit;
    bit          refused;
    set_result_t r;
    pos = 0;
    // Lower bound: first held element not less than v (signed order).
    while (pos < held_total && set_image[pos] < v) pos++;
    hit = (pos < held_total) && (set_image[pos] == v);
    refused = 1'b0;
    case (op)
      MODE_INSERT: begin
        if (!hit) begin
          if (held_total >= CAP) begin
            refused = 1'b1;
          end else begin
            for (int i = held_total; i > pos; i--) set_image[i] = set_image[i-1];
            set_image[pos] = v;
            held_total++;
          end
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          for (int i = pos; i < held_total - 1; i++) set_image[i] = set_image[i+1];
          held_total--;
        end
      end
      default: ; // query and the unused code leave the set alone
    endcase
    r.was_present = hit;
    r.total       = held_total[TOTAL_W-1:0];
    r.refused     = refused;
    expected_results.push_back(r);
  endtask

  // Queue one item. Gaps: mostly none, some short, a few long.
  task automatic add_cmd(input logic [MODE_W-1:0] op, input elem_t v);
    cmd_item_t c;
    int        roll;
    c.op  = op;
    c.val = v;
    c.gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90)      c.gap = $urandom_range(8, 40);
      else if (roll >= 55) c.gap = $urandom_range(1, 3);
    end
    cmd_queue.push_back(c);
  endtask

  // Value source: reuse an earlier value (reuse_pct), an extreme, or fresh bits.
  function automatic elem_t pick_value(input int reuse_pct);
    int    roll;
    elem_t v;
    roll = $urandom_range(0, 99);
    if (roll < reuse_pct && seen_values.size() != 0) begin
      v = seen_values[$urandom_range(0, seen_values.size() - 1)];
    end else if (roll < reuse_pct + 8) begin
      case ($urandom_range(0, 4))
        0: v = ELEM_MIN;
        1: v = ELEM_MAX;
        2: v = 32'sd0;
        3: v = -32'sd1;
        default: v = 32'sd1;
      endcase
    end else begin
      v = elem_t'($urandom);
      seen_values.push_back(v);
    end
    return v;
  endfunction

  // One random item with the given operation mix; the rest is the unused code.
  task automatic add_random(input int ins_pct, input int rem_pct, input int qry_pct,
                            input int reuse_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct)
      add_cmd(MODE_INSERT, pick_value(reuse_pct));
    else if (roll < ins_pct + rem_pct)
      add_cmd(MODE_REMOVE, pick_value(reuse_pct));
    else if (roll < ins_pct + rem_pct + qry_pct)
      add_cmd(MODE_QUERY, pick_value(reuse_pct));
    else
      add_cmd(MODE_UNUSED, pick_value(reuse_pct));
  endtask

  // Driver: offers the head of cmd_queue, holds start through busy, and
  // predicts each item at the edge where start & !busy accepts it.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_set_op(mode, value);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && cmd_queue[0].gap == 0) begin
          issue_cmd = cmd_queue.pop_front();
          start <= 1'b1;
          mode  <= issue_cmd.op;
          value <= issue_cmd.val;
        end else begin
          if (cmd_queue.size() != 0) cmd_queue[0].gap = cmd_queue[0].gap - 1;
          // Junk on the payload while idle; it must be ignored.
          start <= 1'b0;
          mode  <= MODE_W'($urandom);
          value <= elem_t'($urandom);
        end
      end
    end
  end

  // Monitor: every done pulse is one result, checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: was_present=%0b element_total=%0d full_refused=%0b",
               was_present, element_total, full_refused);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (was_present !== want.was_present) begin
          $error("was_present: expected %0b, got %0b", want.was_present, was_present);
          error_count++;
        end
        if (element_total !== want.total) begin
          $error("element_total: expected %0d, got %0d", want.total, element_total);
          error_count++;
        end
        if (full_refused !== want.refused) begin
          $error("full_refused: expected %0b, got %0b", want.refused, full_refused);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_set_table_top_tb failed");
      $finish;
    end
  end

  initial begin
    // Directed: empty set, extremes, duplicates, absent removes,
    // the unused mode code, and removal at the front, middle and back.
    add_cmd(MODE_QUERY,  32'sd0);
    add_cmd(MODE_REMOVE, 32'sd5);          // remove from an empty set
    add_cmd(MODE_UNUSED, 32'sd7);
    add_cmd(MODE_INSERT, 32'sd0);
    add_cmd(MODE_INSERT, ELEM_MIN);
    add_cmd(MODE_INSERT, ELEM_MAX);
    add_cmd(MODE_INSERT, -32'sd1);
    add_cmd(MODE_INSERT, 32'sd1);
    add_cmd(MODE_INSERT, 32'sd0);          // already present
    add_cmd(MODE_INSERT, ELEM_MAX);        // already present
    add_cmd(MODE_QUERY,  ELEM_MIN);
    add_cmd(MODE_QUERY,  ELEM_MAX);
    add_cmd(MODE_QUERY,  32'sd2);          // absent
    add_cmd(MODE_UNUSED, -32'sd1);         // unused code on a present value
    add_cmd(MODE_UNUSED, 32'sd100);        // unused code on an absent value
    add_cmd(MODE_REMOVE, 32'sd0);          // middle
    add_cmd(MODE_REMOVE, 32'sd0);          // now absent
    add_cmd(MODE_REMOVE, ELEM_MIN);        // first entry
    add_cmd(MODE_REMOVE, ELEM_MAX);        // last entry
    add_cmd(MODE_INSERT, 32'sh5555_5555);
    add_cmd(MODE_INSERT, 32'shAAAA_AAAA);
    add_cmd(MODE_QUERY,  32'shAAAA_AAAA);
    add_cmd(MODE_REMOVE, -32'sd1);
    add_cmd(MODE_REMOVE, 32'sd1);
    add_cmd(MODE_REMOVE, 32'sh5555_5555);
    add_cmd(MODE_REMOVE, 32'shAAAA_AAAA);  // back to empty

    // Fill: insert-heavy with fresh values, runs well past capacity so
    // full-store refusals of new values show up.
    for (int n = 0; n < 160; n++) add_random(80, 5, 10, 10);
    // Mixed churn at full pace, no idle gaps.
    gaps_on = 1'b0;
    for (int n = 0; n < 150; n++) add_random(35, 35, 20, 70);
    gaps_on = 1'b1;
    // Drain: remove-heavy, mostly hitting held values, down to empty.
    for (int n = 0; n < 150; n++) add_random(15, 70, 10, 85);
    // Balanced mix around the empty and low-count region.
    for (int n = 0; n < 140; n++) add_random(40, 35, 15, 60);
    issued_total = cmd_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge, clear of the driver and monitor updates.
    do @(negedge clk);
    while (accepted_count != issued_total || expected_results.size() != 0);
    // Let any stray extra result show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("sorted_set_table_top_tb passed");
    end else begin
      $display("sorted_set_table_top_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/ssett_pkg.sv
src/ssett_ram.sv
src/sorted_set_table_top.sv
sim/sorted_set_table_top_tb.sv
